>>> src/ble_abf_pkg.sv
package ble_abf_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // register select is paddr bit 3 (registers at 8 byte spacing)
   localparam logic CSR_TARGET_ENABLED = 1'b0;
   localparam logic CSR_TARGET_ADDRESS = 1'b1;

   localparam logic [7:0] MANUF_TYPE     = 8'hFF;
   localparam logic [7:0] MIN_BEACON_LEN = 8'd21;
   localparam logic [7:0] PREFIX_FIRST   = 8'd2;
   localparam logic [7:0] PREFIX_LAST    = 8'd21;

   typedef struct packed {
      logic              target_enabled;
      logic [47:0]       target_address;
   } cfg_type;

   typedef struct packed {
      logic [7:0]        adv_byte;
      logic              first_byte;
      logic              last_byte;
      logic [47:0]       peer_address;
      logic signed [7:0] signal_strength;
   } item_type;

   typedef struct packed {
      logic              accepted;
      logic [47:0]       sender_address;
      logic signed [7:0] sender_strength;
   } result_type;

   function automatic logic [7:0] beacon_prefix_byte(input logic [4:0] idx);
      logic [7:0] val;
      unique case (idx)
         5'd0:    val = 8'h4c;
         5'd1:    val = 8'h00;
         5'd2:    val = 8'h02;
         5'd3:    val = 8'h15;
         5'd4:    val = 8'h3b;
         5'd5:    val = 8'ha2;
         5'd6:    val = 8'h9c;
         5'd7:    val = 8'hd9;
         5'd8:    val = 8'ha4;
         5'd9:    val = 8'h2c;
         5'd10:   val = 8'h89;
         5'd11:   val = 8'h48;
         5'd12:   val = 8'h56;
         5'd13:   val = 8'hba;
         5'd14:   val = 8'hda;
         5'd15:   val = 8'hf2;
         5'd16:   val = 8'h60;
         5'd17:   val = 8'h6e;
         5'd18:   val = 8'hf7;
         5'd19:   val = 8'h77;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

>>> src/ble_abf_csr.sv
module ble_abf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ble_abf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ble_abf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ble_abf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready,
   output ble_abf_pkg::cfg_type               cfg
);

   logic        target_enabled_ff;
   logic        target_enabled_in;
   logic [47:0] target_address_ff;
   logic [47:0] target_address_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      target_enabled_in = target_enabled_ff;
      target_address_in = target_address_ff;
      if (wr_en) begin
         unique case (csr_paddr[3])
            ble_abf_pkg::CSR_TARGET_ENABLED: target_enabled_in = csr_pwdata[0];
            ble_abf_pkg::CSR_TARGET_ADDRESS: target_address_in = csr_pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         ble_abf_pkg::CSR_TARGET_ENABLED: csr_prdata = {63'd0, target_enabled_ff};
         ble_abf_pkg::CSR_TARGET_ADDRESS: csr_prdata = {16'd0, target_address_ff};
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_enabled_ff <= 1'b0;
         target_address_ff <= 48'd0;
      end else begin
         target_enabled_ff <= target_enabled_in;
         target_address_ff <= target_address_in;
      end
   end

   assign cfg.target_enabled = target_enabled_ff;
   assign cfg.target_address = target_address_ff;

endmodule

>>> src/ble_abf_walk.sv
module ble_abf_walk #(
   parameter int MAX_ADV_LEN = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  ble_abf_pkg::item_type   item,
   input  ble_abf_pkg::cfg_type    cfg,
   output ble_abf_pkg::result_type result
);

   localparam int SEEN_W = $clog2(MAX_ADV_LEN + 1);
   localparam logic [SEEN_W-1:0] MAX_LEN = SEEN_W'(MAX_ADV_LEN);

   logic              walk_ended_ff, walk_ended_in, ended_e;
   logic [7:0]        length_ff, length_in, length_e;
   logic [7:0]        offset_ff, offset_in, offset_e;
   logic              manuf_ff, manuf_in, manuf_e, manuf_now;
   logic              prefix_ff, prefix_in, prefix_e, prefix_now;
   logic              hit_ff, hit_in, hit_e;
   logic [SEEN_W-1:0] seen_ff, seen_in, seen_e;
   logic [47:0]       addr_ff, addr_in;
   logic signed [7:0] strength_ff, strength_in;
   logic [7:0]        b;

   assign b = item.adv_byte;

   always_comb begin
      ended_e     = item.first_byte ? 1'b0 : walk_ended_ff;
      length_e    = item.first_byte ? 8'd0 : length_ff;
      offset_e    = item.first_byte ? 8'd0 : offset_ff;
      manuf_e     = item.first_byte ? 1'b0 : manuf_ff;
      prefix_e    = item.first_byte ? 1'b0 : prefix_ff;
      hit_e       = item.first_byte ? 1'b0 : hit_ff;
      seen_e      = item.first_byte ? '0 : seen_ff;
      addr_in     = item.first_byte ? item.peer_address : addr_ff;
      strength_in = item.first_byte ? item.signal_strength : strength_ff;

      walk_ended_in = ended_e;
      length_in     = length_e;
      offset_in     = offset_e;
      manuf_in      = manuf_e;
      prefix_in     = prefix_e;
      hit_in        = hit_e;
      seen_in       = seen_e;
      manuf_now     = manuf_e;
      prefix_now    = prefix_e;

      if (seen_e < MAX_LEN) begin
         seen_in = seen_e + SEEN_W'(1);
         if (!ended_e) begin
            if (offset_e == 8'd0) begin
               if (b == 8'd0) begin
                  walk_ended_in = 1'b1;
               end else begin
                  length_in = b;
                  offset_in = 8'd1;
                  manuf_in  = 1'b0;
                  prefix_in = 1'b1;
               end
            end else begin
               if (offset_e == 8'd1) begin
                  manuf_now = (b == ble_abf_pkg::MANUF_TYPE);
               end else if (offset_e >= ble_abf_pkg::PREFIX_FIRST &&
                            offset_e <= ble_abf_pkg::PREFIX_LAST &&
                            b != ble_abf_pkg::beacon_prefix_byte(
                                    5'(offset_e - ble_abf_pkg::PREFIX_FIRST))) begin
                  prefix_now = 1'b0;
               end
               manuf_in  = manuf_now;
               prefix_in = prefix_now;
               if (offset_e == length_e) begin
                  if (manuf_now && prefix_now &&
                      length_e >= ble_abf_pkg::MIN_BEACON_LEN) begin
                     hit_in        = 1'b1;
                     walk_ended_in = 1'b1;
                  end
                  offset_in = 8'd0;
               end else begin
                  offset_in = offset_e + 8'd1;
               end
            end
         end
      end

      if (item.last_byte) begin
         walk_ended_in = 1'b1;
      end
   end

   assign result.accepted        = cfg.target_enabled ? (addr_in == cfg.target_address)
                                                      : hit_in;
   assign result.sender_address  = addr_in;
   assign result.sender_strength = strength_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ended_ff <= 1'b0;
         length_ff     <= 8'd0;
         offset_ff     <= 8'd0;
         manuf_ff      <= 1'b0;
         prefix_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         seen_ff       <= '0;
         addr_ff       <= 48'd0;
         strength_ff   <= 8'sd0;
      end else if (fire) begin
         walk_ended_ff <= walk_ended_in;
         length_ff     <= length_in;
         offset_ff     <= offset_in;
         manuf_ff      <= manuf_in;
         prefix_ff     <= prefix_in;
         hit_ff        <= hit_in;
         seen_ff       <= seen_in;
         addr_ff       <= addr_in;
         strength_ff   <= strength_in;
      end
   end

`ifndef SYNTHESIS
   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= MAX_LEN)
      else $error("byte count past maximum length");

   a_ended_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && item.last_byte |=> walk_ended_ff)
      else $error("walk still open after last byte");

   a_hit_ends_walk: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> walk_ended_ff)
      else $error("beacon hit without ended walk");
`endif

endmodule

>>> src/ble_advert_beacon_filter_unit.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  adv_byte first_byte last_byte peer_address
//                                           signal_strength
// rsp       out        rsp_valid/rsp_stall  accepted sender_address sender_strength
// csr       in         apb write/read       target_enabled (0x0) target_address (0x8)
//
// one byte per cycle sustained while req_stall is low; a byte is held in the input register,
// where the walk state updates, and a last byte's result lands in the output register
// synchronous active-high reset clears walk state, captures, config and valid flags
// req_stall rises only when a last-byte beat is held and the output register
// is full and stalled; bytes that make no result always pass
module ble_advert_beacon_filter_unit #(
   parameter int MAX_ADV_LEN = 31
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_adv_byte,
   input  logic                               req_first_byte,
   input  logic                               req_last_byte,
   input  logic [47:0]                        req_peer_address,
   input  logic signed [7:0]                  req_signal_strength,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_accepted,
   output logic [47:0]                        rsp_sender_address,
   output logic signed [7:0]                  rsp_sender_strength,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ble_abf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ble_abf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ble_abf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready
);

   ble_abf_pkg::cfg_type    cfg;
   ble_abf_pkg::item_type   s1_ff, s1_in;
   ble_abf_pkg::result_type res_ff, res_in, walk_res;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    s1_go, s1_fire, req_accept, rsp_accept, load_out;

   ble_abf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ble_abf_walk #(
      .MAX_ADV_LEN (MAX_ADV_LEN)
   ) u_walk (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (s1_ff),
      .cfg    (cfg),
      .result (walk_res)
   );

   assign s1_go      = !s1_ff.last_byte || !out_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && s1_go;
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = out_valid_ff && !rsp_stall;
   assign load_out   = s1_fire && s1_ff.last_byte;

   always_comb begin
      s1_in.adv_byte        = req_adv_byte;
      s1_in.first_byte      = req_first_byte;
      s1_in.last_byte       = req_last_byte;
      s1_in.peer_address    = req_peer_address;
      s1_in.signal_strength = req_signal_strength;

      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_accept) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      res_in = load_out ? walk_res : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_accepted        = res_ff.accepted;
   assign rsp_sender_address  = res_ff.sender_address;
   assign rsp_sender_strength = res_ff.sender_strength;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.last_byte && out_valid_ff && rsp_stall |-> req_stall && !s1_fire)
      else $error("result would overwrite a waiting beat");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      load_out |=> out_valid_ff)
      else $error("last byte produced no result");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_ff.last_byte)
      else $error("input stalled without a held last byte");
`endif

endmodule
